[hw/rtl/msgc_pkg.sv]
// shared types, sizes and helpers for the minimum square guillotine cut block
// used by msgc_table, msgc_min_unit and min_square_guillotine_cut_dp
package msgc_pkg;

    localparam int MAX_LONG_SIDE  = 1024;
    localparam int MAX_SHORT_SIDE = 128;
    localparam int TABLE_DEPTH    = MAX_LONG_SIDE * MAX_SHORT_SIDE;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);

    localparam int SIDE_W   = 11;
    localparam int CELL_W   = 11;
    localparam int SUM_W    = CELL_W + 1;
    localparam int COL_W    = $clog2(MAX_SHORT_SIDE + 1);
    localparam int CELL_MAX = 2047;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CELL,
        S_SHORT,
        S_SPLIT,
        S_DRAIN,
        S_WRITE,
        S_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_ONE,
        OP_INC,
        OP_MIN
    } acc_op_t;

    typedef struct packed {
        acc_op_t op;
        logic    busy;
    } acc_ctl_t;

    // row and column are 1-based
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [SIDE_W-1:0] row,
                                                    input logic [SIDE_W-1:0] col);
        logic [SIDE_W-1:0] row_m1;
        logic [SIDE_W-1:0] col_m1;
        row_m1 = row - SIDE_W'(1);
        col_m1 = col - SIDE_W'(1);
        return ADDR_W'(ADDR_W'(row_m1) * ADDR_W'(MAX_SHORT_SIDE) + ADDR_W'(col_m1));
    endfunction

endpackage

[hw/rtl/msgc_table.sv]
// scratch table of cell counts, one write port and two registered read ports
// depends on msgc_pkg
module msgc_table (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [msgc_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [msgc_pkg::CELL_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [msgc_pkg::ADDR_W-1:0]  rd_addr_a,
    input  logic [msgc_pkg::ADDR_W-1:0]  rd_addr_b,
    output logic [msgc_pkg::CELL_W-1:0]  rd_data_a,
    output logic [msgc_pkg::CELL_W-1:0]  rd_data_b
);
    import msgc_pkg::*;

    logic [CELL_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[hw/rtl/msgc_min_unit.sv]
// shared add and running-minimum unit working on table read data
// depends on msgc_pkg
module msgc_min_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  msgc_pkg::acc_ctl_t           ctl,
    input  logic [msgc_pkg::CELL_W-1:0]  rd_a,
    input  logic [msgc_pkg::CELL_W-1:0]  rd_b,
    output logic [msgc_pkg::CELL_W-1:0]  cell_value
);
    import msgc_pkg::*;

    logic [SUM_W-1:0] best_reg;
    logic [SUM_W-1:0] best_next;
    logic [SUM_W-1:0] pair_sum;

    assign pair_sum = SUM_W'(rd_a) + SUM_W'(rd_b);

    always_comb
    begin
        best_next = best_reg;
        if (ctl.busy)
        begin
            case (ctl.op)
                OP_INIT: best_next = '1;
                OP_ONE:  best_next = SUM_W'(1);
                OP_INC:  best_next = SUM_W'(rd_a) + SUM_W'(1);
                OP_MIN:  best_next = (pair_sum < best_reg) ? pair_sum : best_reg;
                default: best_next = best_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '1;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    // saturate before the value goes back into the table
    assign cell_value = (best_reg > SUM_W'(CELL_MAX)) ? CELL_W'(CELL_MAX)
                                                      : best_reg[CELL_W-1:0];

endmodule

[hw/rtl/min_square_guillotine_cut_dp.sv]
// top level: sequencer over the cut table and the shared minimum unit
// depends on msgc_pkg, msgc_table, msgc_min_unit
//
// one input word on s_* carries the two rectangle sides; one output word on
// m_* carries the least number of squares and the too_large flag.
// s_tready is high only while the sequencer is idle; one rectangle is worked
// on at a time. the sides are ordered so that L >= S, and the table is filled
// row by row through a single two-read memory, one split per cycle.
// per cell: a setup step, then a shortcut step when the sides are equal or the
// shortcut applies, otherwise one step for each horizontal and vertical split
// followed by a pipeline drain, then the write. each query adds accept, range
// check and result steps. the worst case (1024 x 128) is set by the split loop
// through the memory read ports.
// out of range or zero sides go from the range check straight to the done
// state and give a valid word without touching the table.
// the result sits in an output register; a stalled receiver holds it there,
// and the block waits in its done state until the register frees up.
// reset returns the sequencer to idle and clears the output valid; the table
// content is not cleared and needs no clearing, every cell read is written
// earlier in the same query.
module min_square_guillotine_cut_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [msgc_pkg::S_DATA_W-1:0]  s_tdata,  // side_a[10:0], side_b[21:11], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msgc_pkg::M_DATA_W-1:0]  m_tdata,  // min_pieces[10:0], zero pad
    output logic                           m_tuser   // too_large[0]
);
    import msgc_pkg::*;

    localparam int TRI_W = SIDE_W + 2;
    localparam int SQ_W  = 2 * COL_W;
    localparam int CMP_W = (TRI_W > SQ_W) ? TRI_W : SQ_W;

    seq_state_t state_reg, state_next;

    logic [SIDE_W-1:0] lng_reg, lng_next;
    logic [SIDE_W-1:0] sht_reg, sht_next;
    logic              err_reg, err_next;
    logic              zero_reg, zero_next;
    logic [SIDE_W-1:0] row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SIDE_W-1:0] split_reg, split_next;
    logic              vert_reg, vert_next;
    acc_ctl_t          ctl_reg, ctl_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [CELL_W-1:0] pieces_reg, pieces_next;
    logic              too_large_reg, too_large_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [CELL_W-1:0] rd_data_a;
    logic [CELL_W-1:0] rd_data_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] cell_value;

    logic [SIDE_W-1:0] in_a;
    logic [SIDE_W-1:0] in_b;
    logic [SIDE_W-1:0] col_ext;
    logic              diag;
    logic              shortcut;
    logic              horz_end;
    logic              vert_end;
    logic              last_split;
    logic              last_cell;
    logic              out_free;
    logic [TRI_W-1:0]  triple;
    logic [SQ_W-1:0]   col_sq;

    assign in_a     = s_tdata[SIDE_W-1:0];
    assign in_b     = s_tdata[2*SIDE_W-1:SIDE_W];
    assign col_ext  = SIDE_W'(col_reg);
    assign diag     = (row_reg == col_ext);
    assign triple   = TRI_W'(row_reg) + TRI_W'({row_reg, 1'b0});
    assign col_sq   = SQ_W'(col_reg) * SQ_W'(col_reg);
    assign shortcut = (CMP_W'(triple) >= CMP_W'(col_sq));
    assign horz_end = !vert_reg && (split_reg == row_reg - SIDE_W'(1));
    assign vert_end = vert_reg && (split_reg == col_ext - SIDE_W'(1));
    assign last_split = vert_end || (horz_end && (col_reg == COL_W'(1)));
    assign last_cell  = (row_reg == lng_reg) && (col_ext == sht_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    msgc_table u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (cell_value),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    msgc_min_unit u_min (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_reg),
        .rd_a       (rd_data_a),
        .rd_b       (rd_data_b),
        .cell_value (cell_value)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_CHECK;
            S_CHECK: state_next = (err_reg || zero_reg) ? S_DONE : S_CELL;
            S_CELL:  state_next = (diag || shortcut) ? S_SHORT : S_SPLIT;
            S_SHORT: state_next = S_WRITE;
            S_SPLIT: if (last_split) state_next = S_DRAIN;
            S_DRAIN: state_next = S_WRITE;
            S_WRITE: state_next = last_cell ? S_DONE : S_CELL;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        lng_next       = lng_reg;
        sht_next       = sht_reg;
        err_next       = err_reg;
        zero_next      = zero_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        split_next     = split_reg;
        vert_next      = vert_reg;
        ctl_next.op    = OP_HOLD;
        ctl_next.busy  = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        pieces_next    = pieces_reg;
        too_large_next = too_large_reg;
        rd_en          = 1'b0;
        rd_addr_a      = '0;
        rd_addr_b      = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    lng_next  = (in_a < in_b) ? in_b : in_a;
                    sht_next  = (in_a < in_b) ? in_a : in_b;
                    err_next  = (lng_next > SIDE_W'(MAX_LONG_SIDE))
                             || (sht_next > SIDE_W'(MAX_SHORT_SIDE));
                    zero_next = (sht_next == '0);
                end
            end
            S_CHECK:
            begin
                row_next = SIDE_W'(1);
                col_next = COL_W'(1);
            end
            S_CELL:
            begin
                ctl_next.busy = 1'b1;
                if (diag)
                begin
                    ctl_next.op = OP_ONE;
                end
                else if (shortcut)
                begin
                    ctl_next.op = OP_INC;
                    rd_en       = 1'b1;
                    rd_addr_a   = cell_addr(row_reg - col_ext, col_ext);
                end
                else
                begin
                    ctl_next.op = OP_INIT;
                    split_next  = SIDE_W'(1);
                    // a single-row cell has only vertical splits
                    vert_next   = (row_reg == SIDE_W'(1));
                end
            end
            S_SPLIT:
            begin
                ctl_next.op   = OP_MIN;
                ctl_next.busy = 1'b1;
                rd_en         = 1'b1;
                if (vert_reg)
                begin
                    rd_addr_a = cell_addr(row_reg, split_reg);
                    rd_addr_b = cell_addr(row_reg, col_ext - split_reg);
                end
                else
                begin
                    rd_addr_a = cell_addr(split_reg, col_ext);
                    rd_addr_b = cell_addr(row_reg - split_reg, col_ext);
                end
                if (horz_end)
                begin
                    vert_next  = 1'b1;
                    split_next = SIDE_W'(1);
                end
                else
                begin
                    split_next = split_reg + SIDE_W'(1);
                end
            end
            S_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = cell_addr(row_reg, col_ext);
                if (!last_cell)
                begin
                    if (col_ext == sht_reg)
                    begin
                        col_next = COL_W'(1);
                        row_next = row_reg + SIDE_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    // the last cell written is the answer
                    pieces_next    = (err_reg || zero_reg) ? '0 : cell_value;
                    too_large_next = err_reg;
                end
            end
            default:
            begin
                ctl_next.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            err_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            split_reg     <= '0;
            vert_reg      <= 1'b0;
            ctl_reg.op    <= OP_HOLD;
            ctl_reg.busy  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            zero_reg      <= zero_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            split_reg     <= split_next;
            vert_reg      <= vert_next;
            ctl_reg       <= ctl_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lng_reg       <= lng_next;
        sht_reg       <= sht_next;
        pieces_reg    <= pieces_next;
        too_large_reg <= too_large_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(pieces_reg);
    assign m_tuser  = too_large_reg;

    // table writes stay inside the current rectangle
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (row_reg <= lng_reg) && (col_ext <= sht_reg)
                  && (row_reg != '0) && (col_reg != '0))
        else $error("table write outside the current rectangle");

    // every stored count is at least one square
    a_cell_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cell_value != '0))
        else $error("zero count written to the table");

    // an oversized rectangle reports no pieces
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[CELL_W-1:0] == '0))
        else $error("too_large word carries a nonzero count");

    // the minimum unit is only driven while a cell is in progress
    a_ctl_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |=> !ctl_reg.busy)
        else $error("minimum unit active outside a cell");

endmodule
